### design/tmie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape machine instruction executor package
// Sizes, command codes and the record types shared by the executor modules.
// ----------------------------------------------------------------------------
package tmie_pkg;

  localparam int TAPE_DEPTH = 32768;
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int STK_DEPTH  = 64;
  localparam int STK_AW     = $clog2(STK_DEPTH);
  localparam int LVL_W      = STK_AW + 1;
  localparam int ADDR_W     = 16;
  localparam int SKIP_W     = 16;

  localparam logic [TAPE_AW-1:0] TAPE_LAST_RST = TAPE_AW'(29999);
  localparam logic [SKIP_W-1:0]  SKIP_MAX      = '1;

  localparam logic [7:0] CMD_INC   = 8'h2B;
  localparam logic [7:0] CMD_DEC   = 8'h2D;
  localparam logic [7:0] CMD_RIGHT = 8'h3E;
  localparam logic [7:0] CMD_LEFT  = 8'h3C;
  localparam logic [7:0] CMD_OUT   = 8'h2E;
  localparam logic [7:0] CMD_IN    = 8'h2C;
  localparam logic [7:0] CMD_OPEN  = 8'h5B;
  localparam logic [7:0] CMD_CLOSE = 8'h5D;

  typedef struct packed {
    logic [TAPE_AW-1:0] ptr;
    logic [ADDR_W-1:0]  pc;
    logic [LVL_W-1:0]   lvl;
    logic [SKIP_W-1:0]  skip;
    logic               stopped;
  } arch_state_t;

  typedef struct packed {
    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [7:0]         tape_wdata;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic [ADDR_W-1:0]  stk_wdata;
  } mem_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              input_taken;
    logic              halted;
    logic              stack_overflow;
  } result_t;

endpackage

### design/tmie_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape machine instruction step
// Decodes one program byte against the current machine state and the cell
// value, and produces the next state, the memory writes and the result word.
// ----------------------------------------------------------------------------
module tmie_step (
  input  tmie_pkg::arch_state_t          cur_i,
  input  logic [7:0]                     command_i,
  input  logic                           at_end_i,
  input  logic [7:0]                     in_byte_i,
  input  logic [7:0]                     cell_i,
  input  logic [tmie_pkg::ADDR_W-1:0]    stk_top_i,
  input  logic [tmie_pkg::TAPE_AW-1:0]   tape_last_i,
  output tmie_pkg::arch_state_t          nxt_o,
  output tmie_pkg::mem_wr_t              wr_o,
  output tmie_pkg::result_t              res_o
);
  import tmie_pkg::*;

  logic [ADDR_W-1:0]  np;
  logic [TAPE_AW:0]   ptr_n;
  logic               stop;
  logic               ov;
  logic               it;
  logic               so;
  logic [7:0]         ob;

  always_comb begin
    nxt_o = cur_i;
    wr_o  = '0;
    np    = cur_i.pc + ADDR_W'(1);
    ptr_n = {1'b0, cur_i.ptr};
    stop  = cur_i.stopped;
    ov    = 1'b0;
    it    = 1'b0;
    so    = 1'b0;
    ob    = 8'd0;
    wr_o.tape_waddr = cur_i.ptr;
    wr_o.stk_waddr  = cur_i.lvl[STK_AW-1:0];
    wr_o.stk_wdata  = np;
    if (cur_i.stopped || at_end_i) begin
      stop = 1'b1;
    end else if (cur_i.skip != '0) begin
      case (command_i)
        CMD_OPEN: begin
          if (cur_i.skip != SKIP_MAX) nxt_o.skip = cur_i.skip + SKIP_W'(1);
        end
        CMD_CLOSE: nxt_o.skip = cur_i.skip - SKIP_W'(1);
        default: ;
      endcase
      nxt_o.pc = np;
    end else begin
      case (command_i)
        CMD_INC: begin
          wr_o.tape_we    = 1'b1;
          wr_o.tape_wdata = cell_i + 8'd1;
        end
        CMD_DEC: begin
          wr_o.tape_we    = 1'b1;
          wr_o.tape_wdata = cell_i - 8'd1;
        end
        CMD_RIGHT: ptr_n = {1'b0, cur_i.ptr} + (TAPE_AW+1)'(1);
        CMD_LEFT: begin
          if (cur_i.ptr == '0) ptr_n = {1'b0, tape_last_i};
          else ptr_n = {1'b0, cur_i.ptr} - (TAPE_AW+1)'(1);
        end
        CMD_OUT: begin
          ov = 1'b1;
          ob = cell_i;
        end
        CMD_IN: begin
          wr_o.tape_we    = 1'b1;
          wr_o.tape_wdata = in_byte_i;
          it              = 1'b1;
        end
        CMD_OPEN: begin
          if (cell_i == 8'd0) begin
            nxt_o.skip = SKIP_W'(1);
          end else if (cur_i.lvl >= LVL_W'(STK_DEPTH)) begin
            so   = 1'b1;
            stop = 1'b1;
          end else begin
            wr_o.stk_we = 1'b1;
            nxt_o.lvl   = cur_i.lvl + LVL_W'(1);
          end
        end
        CMD_CLOSE: begin
          if (cur_i.lvl == '0) begin
            if (cell_i == 8'd0) stop = 1'b1;
            else np = '0;
          end else if (cell_i != 8'd0) begin
            np = stk_top_i;
          end else begin
            nxt_o.lvl = cur_i.lvl - LVL_W'(1);
          end
        end
        default: ;
      endcase
      if (ptr_n > {1'b0, tape_last_i}) ptr_n = '0;
      nxt_o.ptr = ptr_n[TAPE_AW-1:0];
      if (!stop) nxt_o.pc = np;
    end
    nxt_o.stopped = stop;
    res_o.next_address   = nxt_o.pc;
    res_o.out_valid      = ov;
    res_o.out_byte       = ob;
    res_o.input_taken    = it;
    res_o.halted         = stop;
    res_o.stack_overflow = so;
  end

endmodule

### design/tape_machine_instruction_executor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape machine instruction executor
// Runs one program byte per word against a byte tape held in block memory.
// ----------------------------------------------------------------------------
// The host sends one word per program byte on the command channel (command,
// at_end, in_byte) and receives one result word per command word on the
// result channel. The host fetches the byte at next_address of the latest
// result; the first byte is at address zero. tape_last is to be written
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does
// not enforce this. A new command word is taken in every cycle while
// cmd_stall_o is low: its tape cell and loop stack entry are read in the
// accept cycle from the state left by the word ahead, and a write to the
// same entry in that cycle is forwarded. The tape read-modify-write and the
// loop stack read set this one word per cycle.
// After reset a sweep clears all 32768 tape cells, one cell per cycle, during
// which cmd_stall_o is high; configuration writes are taken.
// When the receiver stalls, the result word holds in the output register, one
// more command word can be taken and waits in the execute stage, and then
// cmd_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmie_pkg::TAPE_AW-1:0]  cfg_wdata_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_stall_o,
  input  logic [7:0]                    command_i,
  input  logic                          at_end_i,
  input  logic [7:0]                    in_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [tmie_pkg::ADDR_W-1:0]   next_address_o,
  output logic                          out_valid_o,
  output logic [7:0]                    out_byte_o,
  output logic                          input_taken_o,
  output logic                          halted_o,
  output logic                          stack_overflow_o
);
  import tmie_pkg::*;

  logic [7:0]         tape_mem [TAPE_DEPTH];
  logic [ADDR_W-1:0]  stk_mem  [STK_DEPTH];

  logic [TAPE_AW-1:0] tape_last_q;
  logic               clr_q;
  logic [TAPE_AW-1:0] clr_cnt_q;
  arch_state_t        state_q, state_d, nxt;
  mem_wr_t            wr;
  result_t            res, res_q;
  logic               res_valid_q;

  logic               e_valid_q;
  logic [7:0]         e_cmd_q;
  logic               e_end_q;
  logic [7:0]         e_in_q;
  logic               e_go;
  logic               in_acc;

  logic [7:0]         tape_rd_q;
  logic               tape_fwd_q;
  logic [7:0]         tape_fwd_data_q;
  logic [ADDR_W-1:0]  stk_rd_q;
  logic               stk_fwd_q;
  logic [ADDR_W-1:0]  stk_fwd_data_q;

  logic               tape_we;
  logic [TAPE_AW-1:0] tape_wa;
  logic [7:0]         tape_wd;
  logic               stk_we;
  logic [LVL_W-1:0]   lvl_m1;
  logic [STK_AW-1:0]  stk_ra;
  logic [7:0]         cell_rd;
  logic [ADDR_W-1:0]  stk_top;

  assign e_go        = e_valid_q && (!res_valid_q || !res_stall_i);
  assign cmd_stall_o = clr_q || (e_valid_q && !e_go);
  assign in_acc      = cmd_valid_i && !cmd_stall_o;

  assign cell_rd = tape_fwd_q ? tape_fwd_data_q : tape_rd_q;
  assign stk_top = stk_fwd_q ? stk_fwd_data_q : stk_rd_q;

  tmie_step u_step (
    .cur_i       (state_q),
    .command_i   (e_cmd_q),
    .at_end_i    (e_end_q),
    .in_byte_i   (e_in_q),
    .cell_i      (cell_rd),
    .stk_top_i   (stk_top),
    .tape_last_i (tape_last_q),
    .nxt_o       (nxt),
    .wr_o        (wr),
    .res_o       (res)
  );

  assign state_d = e_go ? nxt : state_q;
  assign tape_we = clr_q || (e_go && wr.tape_we);
  assign tape_wa = clr_q ? clr_cnt_q : wr.tape_waddr;
  assign tape_wd = clr_q ? 8'd0 : wr.tape_wdata;
  assign stk_we  = e_go && wr.stk_we;
  assign lvl_m1  = state_d.lvl - LVL_W'(1);
  assign stk_ra  = lvl_m1[STK_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_wa] <= tape_wd;
    if (in_acc) begin
      tape_rd_q       <= tape_mem[state_d.ptr];
      tape_fwd_data_q <= tape_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[wr.stk_waddr] <= wr.stk_wdata;
    if (in_acc) begin
      stk_rd_q       <= stk_mem[stk_ra];
      stk_fwd_data_q <= wr.stk_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_fwd_q <= 1'b0;
      stk_fwd_q  <= 1'b0;
    end else if (in_acc) begin
      tape_fwd_q <= tape_we && (tape_wa == state_d.ptr);
      stk_fwd_q  <= stk_we && (wr.stk_waddr == stk_ra);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + TAPE_AW'(1);
      if (clr_cnt_q == TAPE_AW'(TAPE_DEPTH - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_last_q <= TAPE_LAST_RST;
    end else if (cfg_we_i) begin
      tape_last_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (in_acc) begin
      e_valid_q <= 1'b1;
    end else if (e_go) begin
      e_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_cmd_q <= command_i;
      e_end_q <= at_end_i;
      e_in_q  <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (e_go) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_go) res_q <= res;
  end

  assign res_valid_o      = res_valid_q;
  assign next_address_o   = res_q.next_address;
  assign out_valid_o      = res_q.out_valid;
  assign out_byte_o       = res_q.out_byte;
  assign input_taken_o    = res_q.input_taken;
  assign halted_o         = res_q.halted;
  assign stack_overflow_o = res_q.stack_overflow;

endmodule

### design/tmie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape machine instruction executor checker
// Port-level properties of the executor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tmie_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_stall_o,
  input logic                          res_valid_o,
  input logic                          res_stall_i,
  input logic                          out_valid_o,
  input logic                          input_taken_o,
  input logic                          halted_o,
  input logic                          stack_overflow_o
);
  import tmie_pkg::*;

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (res_valid_o && !res_stall_i && halted_o) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result word dropped while stalled");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && seen_halt_q |-> halted_o)
    else $error("machine left the halted state");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && halted_o |-> !out_valid_o && !input_taken_o)
    else $error("halted word carries input or output");

  a_ovf_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && stack_overflow_o |-> halted_o)
    else $error("stack overflow without halt");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> cmd_stall_o)
    else $error("command taken before the tape was cleared");

endmodule

bind tape_machine_instruction_executor_unit tmie_checker u_tmie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_stall_o      (cmd_stall_o),
  .res_valid_o      (res_valid_o),
  .res_stall_i      (res_stall_i),
  .out_valid_o      (out_valid_o),
  .input_taken_o    (input_taken_o),
  .halted_o         (halted_o),
  .stack_overflow_o (stack_overflow_o)
);
